// ===== design/height_average_failsafe_weight_macros.svh =====
// Assertion macros used by the port-level checker of the height averaging block.
`ifndef HEIGHT_AVERAGE_FAILSAFE_WEIGHT_MACROS_SVH
`define HEIGHT_AVERAGE_FAILSAFE_WEIGHT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HAFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define HAFW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hafw_pkg.sv =====
// Shared constants, types and command structs of the height averaging block.
package hafw_pkg;

  // Field and accumulator widths.
  localparam int HEIGHT_W  = 16;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 8;
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int PROD_W    = HEIGHT_W + COEF_W;
  localparam int LOAD_W    = PROD_W + 2;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Port widths.
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  // Averaging window in slow mode and the weight deadband in kg.
  localparam logic [CNT_W-1:0]    SLOW_WINDOW     = 8'd100;
  localparam logic [HEIGHT_W-1:0] WEIGHT_DEADBAND = 16'd20;

  // Register reset values.
  localparam logic [HEIGHT_W-1:0] DEAD_WEIGHT_RESET = 16'd200;
  localparam logic [COEF_W-1:0]   COEF_RESET        = 32'd134300;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_WEIGHT = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF        = 8'd1;

  // Bit positions inside in_tuser.
  localparam int USR_LEFT_OK  = 0;
  localparam int USR_RIGHT_OK = 1;
  localparam int USR_NORMAL   = 2;
  localparam int USR_SLOW     = 3;
  localparam int USR_LIFTED   = 4;

  // Operand selection for the shared divider.
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_LH = 2'd0;
  localparam div_sel_t DIV_RH = 2'd1;
  localparam div_sel_t DIV_LP = 2'd2;
  localparam div_sel_t DIV_RP = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     acc;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     mul;
    logic     load;
    logic     pub;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pub_now;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/hafw_div.sv =====
// Restoring divider: 24-bit dividend by 8-bit divisor, one quotient bit per cycle.
module hafw_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hafw_pkg::SUM_W-1:0]    dividend,
  input  logic [hafw_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [hafw_pkg::HEIGHT_W-1:0] quotient
);
  import hafw_pkg::*;

  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[HEIGHT_W-1:0];

endmodule

// ===== design/hafw_dp.sv =====
// Datapath: configuration registers, sums, divider, weight estimate and output register.
module hafw_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hafw_pkg::ctrl_cmd_t             cmd,
  output hafw_pkg::dp_status_t            status,
  input  logic [hafw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [hafw_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            cfg_valid,
  input  logic [hafw_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hafw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hafw_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [hafw_pkg::OUT_USER_W-1:0] out_tuser
);
  import hafw_pkg::*;

  // Input fields.
  logic [HEIGHT_W-1:0] lh, rh, lp, rp, lpr, rpr;
  logic                lok, rok, normal, slow, lifted;

  assign lh     = in_tdata[15:0];
  assign rh     = in_tdata[31:16];
  assign lp     = in_tdata[47:32];
  assign rp     = in_tdata[63:48];
  assign lpr    = in_tdata[79:64];
  assign rpr    = in_tdata[95:80];
  assign lok    = in_tuser[USR_LEFT_OK];
  assign rok    = in_tuser[USR_RIGHT_OK];
  assign normal = in_tuser[USR_NORMAL];
  assign slow   = in_tuser[USR_SLOW];
  assign lifted = in_tuser[USR_LIFTED];

  logic [HEIGHT_W-1:0] dead_r;
  logic [COEF_W-1:0]   coef_r;
  logic [SUM_W-1:0]    lh_sum_r, rh_sum_r, lp_sum_r, rp_sum_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [HEIGHT_W-1:0] pub_r;
  logic                normal_r, lifted_r;
  logic [HEIGHT_W-1:0] q_lh_r, q_rh_r, q_lp_r, q_rp_r;
  logic [PROD_W-1:0]   prod_r;
  logic [LOAD_W-1:0]   load_r;
  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_lavg_r, out_ravg_r, out_load_r;
  logic                out_upd_r;

  logic [HEIGHT_W-1:0] add_l, add_r;
  logic [SUM_W-1:0]    dividend;
  logic                div_done;
  logic [HEIGHT_W-1:0] quotient;
  logic [HEIGHT_W:0]   mean_sum;
  logic [HEIGHT_W-1:0] mean;
  logic [LOAD_W-1:0]   w_full, dead_full;
  logic [LOAD_W-1:0]   up_thr, down_thr;
  logic                up, down;
  logic [HEIGHT_W-1:0] kg_sat;
  logic [HEIGHT_W-1:0] pub_nxt;
  logic                upd_nxt;
  logic                out_free;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= DEAD_WEIGHT_RESET;
      coef_r <= COEF_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_DEAD_WEIGHT: dead_r <= cfg_data[HEIGHT_W-1:0];
        CFG_COEF:        coef_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Failsafe: healthy side for a broken one; both broken: raw pressures in normal state.
  always_comb begin
    add_l = '0;
    add_r = '0;
    if (lok && rok) begin
      add_l = lh;
      add_r = rh;
    end else if (rok) begin
      add_l = rh;
      add_r = rh;
    end else if (lok) begin
      add_l = lh;
      add_r = lh;
    end else if (normal) begin
      add_l = lpr;
      add_r = rpr;
    end
  end

  // Publish decision for the request now being accepted.
  assign count_nxt      = count_r + 1'b1;
  assign status.pub_now = !slow || (count_nxt >= SLOW_WINDOW);

  // Running sums and sample count; cleared after each publish.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lh_sum_r <= '0;
      rh_sum_r <= '0;
      lp_sum_r <= '0;
      rp_sum_r <= '0;
      count_r  <= '0;
    end else if (cmd.acc) begin
      lh_sum_r <= lh_sum_r + SUM_W'(add_l);
      rh_sum_r <= rh_sum_r + SUM_W'(add_r);
      lp_sum_r <= lp_sum_r + SUM_W'(lp);
      rp_sum_r <= rp_sum_r + SUM_W'(rp);
      count_r  <= count_nxt;
    end else if (cmd.pub) begin
      lh_sum_r <= '0;
      rh_sum_r <= '0;
      lp_sum_r <= '0;
      rp_sum_r <= '0;
      count_r  <= '0;
    end
  end

  // Mode flags of the tick that may publish.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      normal_r <= normal;
      lifted_r <= lifted;
    end
  end

  // Shared divider and its operand selection.
  always_comb begin
    case (cmd.div_sel)
      DIV_LH:  dividend = lh_sum_r;
      DIV_RH:  dividend = rh_sum_r;
      DIV_LP:  dividend = lp_sum_r;
      DIV_RP:  dividend = rp_sum_r;
      default: dividend = lh_sum_r;
    endcase
  end

  hafw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.div_done = div_done;

  // Quotient capture.
  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        DIV_LH:  q_lh_r <= quotient;
        DIV_RH:  q_rh_r <= quotient;
        DIV_LP:  q_lp_r <= quotient;
        DIV_RP:  q_rp_r <= quotient;
        default: q_lh_r <= quotient;
      endcase
    end
  end

  // Mean pressure times the per-cylinder coefficient.
  assign mean_sum = {1'b0, q_lp_r} + {1'b0, q_rp_r};
  assign mean     = mean_sum[HEIGHT_W:1];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mean) * PROD_W'(coef_r);
    end
  end

  // Cylinder count as a shift, then the dead weight taken off, floored at zero.
  assign w_full    = lifted_r ? {1'b0, prod_r, 1'b0} : {prod_r, 2'b00};
  assign dead_full = {{(LOAD_W-HEIGHT_W-FRAC_W){1'b0}}, dead_r, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      load_r <= (w_full > dead_full) ? (w_full - dead_full) : '0;
    end
  end

  // Deadband test and the new published weight.
  always_comb begin
    up_thr   = {{(LOAD_W-HEIGHT_W-1-FRAC_W){1'b0}},
                ({1'b0, pub_r} + {1'b0, WEIGHT_DEADBAND}), {FRAC_W{1'b0}}};
    down_thr = {{(LOAD_W-HEIGHT_W-FRAC_W){1'b0}}, pub_r - WEIGHT_DEADBAND,
                {FRAC_W{1'b0}}};
    up       = load_r > up_thr;
    down     = (pub_r > WEIGHT_DEADBAND) && (load_r < down_thr);
    kg_sat   = (|load_r[LOAD_W-1:FRAC_W+HEIGHT_W]) ? {HEIGHT_W{1'b1}}
                                                   : load_r[FRAC_W+HEIGHT_W-1:FRAC_W];
    pub_nxt  = pub_r;
    upd_nxt  = 1'b0;
    if (normal_r) begin
      if (up || down) begin
        pub_nxt = kg_sat;
        upd_nxt = 1'b1;
      end
    end else if (pub_r != '0) begin
      pub_nxt = '0;
      upd_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_r <= '0;
    end else if (cmd.pub) begin
      pub_r <= pub_nxt;
    end
  end

  // Output register: holds a result until the consumer takes it.
  assign out_free        = !out_valid_r || out_tready;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pub) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pub) begin
      out_lavg_r <= q_lh_r;
      out_ravg_r <= q_rh_r;
      out_load_r <= pub_nxt;
      out_upd_r  <= upd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_load_r, out_ravg_r, out_lavg_r};
  assign out_tuser  = out_upd_r;

endmodule

// ===== design/hafw_ctrl.sv =====
// Controller: sequences accumulation, the four divisions, the weight steps and publish.
module hafw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  hafw_pkg::dp_status_t status,
  output hafw_pkg::ctrl_cmd_t  cmd
);
  import hafw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DSTART = 6'b000010,
    S_DWAIT  = 6'b000100,
    S_MUL    = 6'b001000,
    S_LOAD   = 6'b010000,
    S_PUB    = 6'b100000
  } state_t;

  state_t   state_r, state_nxt;
  div_sel_t idx_r, idx_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cmd             = '0;
    cmd.div_sel     = idx_r;
    in_tready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (status.pub_now) begin
            idx_nxt   = DIV_LH;
            state_nxt = S_DSTART;
          end
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          if (idx_r == DIV_RP) begin
            state_nxt = S_MUL;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (status.out_free) begin
          cmd.pub   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= DIV_LH;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== design/height_average_failsafe_weight.sv =====
// Top level of the failsafe height averaging and load weight block.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_tvalid/tready   | tdata 96 bits, tuser 5 bits
//  out_    | output    | out_tvalid/tready  | tdata 48 bits, tuser 1 bit
//  cfg_    | input     | cfg_valid/ready    | cfg_addr register index, cfg_data
//
// A tick that does not publish leaves the input open. A publishing tick is accepted and
// then keeps the input closed: each of the four divisions on the shared restoring divider
// takes a start, 24 steps and a capture, then come multiply, load and publish.
// Reset (rst_n low, synchronous) clears the sums, the count, the published weight
// and the output register, and restores the register defaults.
// A stalled result waits in the output register; non-publishing ticks are still taken.
module height_average_failsafe_weight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // lh[15:0], rh[31:16], lp_kpa[47:32], rp_kpa[63:48], lp_raw[79:64], rp_raw[95:80]
  input  logic [hafw_pkg::IN_DATA_W-1:0]  in_tdata,
  // left_ok[0], right_ok[1], at_normal[2], slow_mode[3], rear_lifted[4]
  input  logic [hafw_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // left_avg[15:0], right_avg[31:16], load_weight_kg[47:32]
  output logic [hafw_pkg::OUT_DATA_W-1:0] out_tdata,
  // weight_updated[0]
  output logic [hafw_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hafw_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hafw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hafw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  hafw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hafw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/hafw_checker.sv =====
// Port-level checker of the height averaging block and its bind.
`include "height_average_failsafe_weight_macros.svh"

module hafw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [hafw_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hafw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [hafw_pkg::OUT_USER_W-1:0] out_tuser
);
  import hafw_pkg::*;

  // A stalled result stays offered.
  `HAFW_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `HAFW_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A fast-mode request always publishes, so the controller keeps the input closed next cycle.
  `HAFW_ASSERT(a_fast_busy, in_tvalid && in_tready && !in_tuser[USR_SLOW] |=> !in_tready, "input open after publishing request")

  // Reset empties the output register.
  `HAFW_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result offered after reset")

endmodule

bind height_average_failsafe_weight hafw_checker u_hafw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/hafw_average_check.sv =====
// Checker that predicts the published height averages and load weight and compares them.
module hafw_average_check
  import hafw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // lh, rh, lp_kpa, rp_kpa, lp_raw, rp_raw from the lowest bit up
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // left_ok, right_ok, at_normal, slow_mode, rear_lifted from the lowest bit up
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // left_avg, right_avg, load_weight_kg from the lowest bit up
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // weight_updated
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked_count,
  output int                    update_count
);

  typedef struct packed {
    logic [HEIGHT_W-1:0] left_avg;
    logic [HEIGHT_W-1:0] right_avg;
    logic [HEIGHT_W-1:0] weight_kg;
    logic                updated;
  } publish_t;

  // Predicted block state and register copies.
  logic [SUM_W-1:0]    lh_sum;
  logic [SUM_W-1:0]    rh_sum;
  logic [SUM_W-1:0]    lp_sum;
  logic [SUM_W-1:0]    rp_sum;
  logic [CNT_W-1:0]    ticks;
  logic [HEIGHT_W-1:0] pub_kg;
  logic [HEIGHT_W-1:0] dead_kg;
  logic [COEF_W-1:0]   kg_per_kpa;

  publish_t expected_publish_q[$];
  int       n_fail = 0;
  int       n_checked = 0;
  int       n_updates = 0;

  function automatic bit field_ok(input string what, input int unsigned want, got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    return 1'b0;
  endfunction

  // Folds one sample tick into the sums; returns 1 with the result on a publish tick.
  function automatic bit absorb_tick(input logic [IN_DATA_W-1:0] d,
                                     input logic [IN_USER_W-1:0] u,
                                     output publish_t res);
    logic [HEIGHT_W-1:0] lh, rh, lp, rp, lpr, rpr;
    logic                lok, rok, normal, slow, lifted;
    logic [SUM_W-1:0]    div;
    logic [31:0]         mean;
    logic [63:0]         w, dead, load, cur, kg;
    logic                up, down;
    lh     = d[15:0];
    rh     = d[31:16];
    lp     = d[47:32];
    rp     = d[63:48];
    lpr    = d[79:64];
    rpr    = d[95:80];
    lok    = u[USR_LEFT_OK];
    rok    = u[USR_RIGHT_OK];
    normal = u[USR_NORMAL];
    slow   = u[USR_SLOW];
    lifted = u[USR_LIFTED];
    res    = '0;

    lp_sum = lp_sum + SUM_W'(lp);
    rp_sum = rp_sum + SUM_W'(rp);

    // Failsafe substitution: a healthy side stands in for a broken one; both broken: raw pressures in normal state.
    if (lok && rok) begin
      lh_sum = lh_sum + SUM_W'(lh);
      rh_sum = rh_sum + SUM_W'(rh);
    end else if (rok) begin
      lh_sum = lh_sum + SUM_W'(rh);
      rh_sum = rh_sum + SUM_W'(rh);
    end else if (lok) begin
      lh_sum = lh_sum + SUM_W'(lh);
      rh_sum = rh_sum + SUM_W'(lh);
    end else if (normal) begin
      lh_sum = lh_sum + SUM_W'(lpr);
      rh_sum = rh_sum + SUM_W'(rpr);
    end

    ticks = ticks + 1'b1;
    if (slow && ticks < SLOW_WINDOW) return 1'b0;

    div = SUM_W'(ticks);
    res.left_avg  = HEIGHT_W'(lh_sum / div);
    res.right_avg = HEIGHT_W'(rh_sum / div);

    // Load estimate in Q.24, with a deadband around the published weight; cleared outside normal state.
    if (normal) begin
      mean = (32'(lp_sum / div) + 32'(rp_sum / div)) / 2;
      w    = 64'(mean) * (lifted ? 64'd2 : 64'd4) * 64'(kg_per_kpa);
      dead = 64'(dead_kg) << FRAC_W;
      load = (w > dead) ? w - dead : 64'd0;
      cur  = 64'(pub_kg);
      up   = load > ((cur + 64'(WEIGHT_DEADBAND)) << FRAC_W);
      down = (cur > 64'(WEIGHT_DEADBAND)) &&
             (load < ((cur - 64'(WEIGHT_DEADBAND)) << FRAC_W));
      if (up || down) begin
        kg          = load >> FRAC_W;
        pub_kg      = (kg > 64'hFFFF) ? 16'hFFFF : HEIGHT_W'(kg);
        res.updated = 1'b1;
      end
    end else if (pub_kg != '0) begin
      pub_kg      = '0;
      res.updated = 1'b1;
    end

    lh_sum = '0;
    rh_sum = '0;
    lp_sum = '0;
    rp_sum = '0;
    ticks  = '0;
    res.weight_kg = pub_kg;
    return 1'b1;
  endfunction

  // Results are matched first, then register writes and new requests are absorbed.
  always @(posedge clk) begin : watch
    publish_t want, got, fresh;
    bit       ok;
    if (!rst_n) begin
      lh_sum     = '0;
      rh_sum     = '0;
      lp_sum     = '0;
      rp_sum     = '0;
      ticks      = '0;
      pub_kg     = '0;
      dead_kg    = DEAD_WEIGHT_RESET;
      kg_per_kpa = COEF_RESET;
      expected_publish_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.left_avg  = out_tdata[HEIGHT_W-1:0];
        got.right_avg = out_tdata[2*HEIGHT_W-1:HEIGHT_W];
        got.weight_kg = out_tdata[3*HEIGHT_W-1:2*HEIGHT_W];
        got.updated   = out_tuser[0];
        if (expected_publish_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h/%b",
                   $time, out_tdata, out_tuser);
          n_fail++;
        end else begin
          want = expected_publish_q.pop_front();
          ok = field_ok("left height average", want.left_avg, got.left_avg);
          ok = field_ok("right height average", want.right_avg, got.right_avg) & ok;
          ok = field_ok("load weight", want.weight_kg, got.weight_kg) & ok;
          ok = field_ok("weight updated flag", want.updated, got.updated) & ok;
          n_checked++;
          if (!ok) n_fail++;
          if (got.updated) n_updates++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_DEAD_WEIGHT: dead_kg = cfg_data[HEIGHT_W-1:0];
          CFG_COEF:        kg_per_kpa = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (absorb_tick(in_tdata, in_tuser, fresh)) expected_publish_q.push_back(fresh);
      end
    end
    fail_count    <= n_fail;
    pending       <= expected_publish_q.size();
    checked_count <= n_checked;
    update_count  <= n_updates;
  end

endmodule

// ===== dv/height_average_failsafe_weight_tb.sv =====
// Testbench top: drives sample ticks and register writes and reports the verdict.
module height_average_failsafe_weight_tb;
  import hafw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_TICKS = 190;

  // Register indexes the block does not decode.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 8'hFF;

  typedef struct packed {
    logic [HEIGHT_W-1:0] lh, rh, lp_kpa, rp_kpa, lp_raw, rp_raw;
    logic                lok, rok, normal, slow, lifted;
  } sample_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // lh, rh, lp_kpa, rp_kpa, lp_raw, rp_raw from the lowest bit up
  logic [IN_DATA_W-1:0]  in_tdata;
  // left_ok, right_ok, at_normal, slow_mode, rear_lifted from the lowest bit up
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // left_avg, right_avg, load_weight_kg from the lowest bit up
  logic [OUT_DATA_W-1:0] out_tdata;
  // weight_updated
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked_count;
  int update_count;
  int n_sent = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  bit stall_en = 1'b1;

  height_average_failsafe_weight i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  hafw_average_check i_publish_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .update_count  (update_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ends the run when no channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic sample_t tick_of(input logic [15:0] lh, rh, input logic lok, rok,
                                      input logic [15:0] lp, rp, lpr, rpr,
                                      input logic normal, slow, lifted);
    sample_t s;
    s = '{lh, rh, lp, rp, lpr, rpr, lok, rok, normal, slow, lifted};
    return s;
  endfunction

  function automatic logic [15:0] near_level(input int base, jitter);
    int v;
    v = base + int'($urandom_range(0, 2 * jitter)) - jitter;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Well-formed ticks keep pressures near a level; noisy ticks randomize everything.
  function automatic sample_t random_tick(input bit noisy, input logic normal, slow, lifted,
                                          input int base, jitter);
    sample_t s;
    s.lh     = 16'($urandom);
    s.rh     = 16'($urandom);
    s.lp_raw = 16'($urandom);
    s.rp_raw = 16'($urandom);
    if (noisy) begin
      s.lp_kpa = 16'($urandom);
      s.rp_kpa = 16'($urandom);
      s.lok    = 1'($urandom);
      s.rok    = 1'($urandom);
      s.normal = 1'($urandom);
      s.slow   = 1'($urandom);
      s.lifted = 1'($urandom);
    end else begin
      s.lp_kpa = near_level(base, jitter);
      s.rp_kpa = near_level(base, jitter);
      s.lok    = $urandom_range(0, 7) != 0;
      s.rok    = $urandom_range(0, 7) != 0;
      s.normal = normal;
      s.slow   = slow;
      s.lifted = lifted;
    end
    return s;
  endfunction

  // Presents one tick, possibly after an idle burst, and waits for its acceptance.
  task automatic send_tick(input sample_t s);
    logic [IN_USER_W-1:0] flags;
    flags               = '0;
    flags[USR_LEFT_OK]  = s.lok;
    flags[USR_RIGHT_OK] = s.rok;
    flags[USR_NORMAL]   = s.normal;
    flags[USR_SLOW]     = s.slow;
    flags[USR_LIFTED]   = s.lifted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.rp_raw, s.lp_raw, s.rp_kpa, s.lp_kpa, s.rh, s.lh};
    in_tuser  <= flags;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected result, then lets a silent tick finish inside the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int   kind, len, base, jitter;
    logic normal, lifted;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks with the reset register values.
    send_tick(tick_of(16'h0000, 16'hFFFF, 1, 1, 16'h0000, 16'h0000, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'hFFFF, 16'h0000, 1, 1, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0, 1));
    // Left sensor broken, then right sensor broken.
    send_tick(tick_of(16'd1000, 16'd2000, 0, 1, 16'd30000, 16'd30000, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'd1000, 16'd2000, 1, 0, 16'd30000, 16'd30000, 0, 0, 1, 0, 0));
    // Both broken in normal state falls back to raw pressures.
    send_tick(tick_of(16'd1000, 16'd2000, 0, 0, 16'd30000, 16'd30000, 16'hFFFF, 0, 1, 0, 0));
    // Both broken outside normal state: weight cleared, then stays cleared.
    send_tick(tick_of(16'd1000, 16'd2000, 0, 0, 16'd30000, 16'd30000, 16'hFFFF, 16'hFFFF,
                      0, 0, 0));
    send_tick(tick_of(16'd1000, 16'd2000, 0, 0, 16'd30000, 16'd30000, 16'hFFFF, 16'hFFFF,
                      0, 0, 1));
    // Partial slow window cut short by a switch to fast mode.
    send_tick(tick_of(16'd100, 16'd200, 1, 1, 16'd10000, 16'd12000, 0, 0, 1, 1, 0));
    send_tick(tick_of(16'd300, 16'd400, 1, 0, 16'd11000, 16'd13000, 0, 0, 1, 1, 0));
    send_tick(tick_of(16'd500, 16'd600, 0, 1, 16'd14000, 16'd9000, 0, 0, 1, 1, 0));
    send_tick(tick_of(16'd700, 16'd800, 0, 0, 16'd15000, 16'd8000, 16'd50, 16'd60, 1, 1, 0));
    send_tick(tick_of(16'd900, 16'd950, 0, 0, 16'd16000, 16'd7000, 16'd70, 16'd80, 0, 1, 0));
    send_tick(tick_of(16'd1100, 16'd1200, 1, 1, 16'd17000, 16'd6000, 0, 0, 1, 0, 0));
    // All fields at zero, then all at their maximum followed by a fast tick.
    send_tick(tick_of(16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0));
    send_tick(tick_of(16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      1, 1, 1));
    send_tick(tick_of(16'd5, 16'd6, 1, 1, 16'h0000, 16'h0000, 0, 0, 1, 0, 0));
    // Deadband: small moves hold the weight, large ones rewrite it.
    send_tick(tick_of(16'd10, 16'd20, 1, 1, 16'd20000, 16'd20000, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'd10, 16'd20, 1, 1, 16'd20300, 16'd20300, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'd10, 16'd20, 1, 1, 16'd22000, 16'd22000, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'd10, 16'd20, 1, 1, 16'd21500, 16'd21500, 0, 0, 1, 0, 0));
    send_tick(tick_of(16'd10, 16'd20, 1, 1, 16'd20000, 16'd20000, 0, 0, 1, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      // Register settings change only while the block is idle.
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(CFG_DEAD_WEIGHT, 32'd0);
            write_reg(CFG_COEF, 32'hFFFF_FFFF);
            write_reg(CFG_SPARE, $urandom);
            write_reg(CFG_NO_REG, $urandom);
          end
          2: begin
            write_reg(CFG_DEAD_WEIGHT, 32'h0000_FFFF);
            write_reg(CFG_COEF, 32'd0);
          end
          3: begin
            write_reg(CFG_DEAD_WEIGHT, 32'($urandom_range(0, 3000)));
            write_reg(CFG_COEF, $urandom_range(32'h0010_0000, 32'h0400_0000));
          end
          default: begin
            write_reg(CFG_DEAD_WEIGHT, 32'($urandom_range(0, 1500)));
            write_reg(CFG_COEF, $urandom);
          end
        endcase
      end
      if (ph == 4) begin
        idle_en  = 1'b0;
        stall_en = 1'b0;
      end

      while (n_sent < (ph + 1) * PHASE_TICKS) begin
        kind   = $urandom_range(0, 19);
        normal = $urandom_range(0, 7) != 0;
        lifted = 1'($urandom);
        base   = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8000);
        jitter = $urandom_range(0, 1500);
        if (ph < 4) begin
          idle_en  = $urandom_range(0, 3) != 0;
          stall_en = $urandom_range(0, 3) != 0;
        end
        if (kind < 9) begin
          // Fast mode: every tick publishes.
          len = $urandom_range(1, 15);
          repeat (len)
            send_tick(random_tick(1'b0, normal ^ ($urandom_range(0, 15) == 0), 1'b0, lifted,
                                  base, jitter));
        end else if (kind < 12) begin
          // One full slow window.
          repeat (SLOW_WINDOW)
            send_tick(random_tick(1'b0, normal, 1'b1, lifted, base, jitter));
        end else if (kind < 16) begin
          // A partial slow window ended by a fast tick.
          len = $urandom_range(1, 60);
          repeat (len) send_tick(random_tick(1'b0, normal, 1'b1, lifted, base, jitter));
          send_tick(random_tick(1'b0, normal, 1'b0, lifted, base, jitter));
        end else begin
          len = $urandom_range(1, 10);
          repeat (len) send_tick(random_tick(1'b1, normal, 1'b0, lifted, base, jitter));
        end
      end
    end

    drain();
    $display("Sent %0d sample ticks over five register settings, with fast runs,", n_sent);
    $display("full and cut-short slow windows; %0d results checked, %0d weight rewrites.",
             checked_count, update_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
